// ===== sv/kss_pkg.sv =====
`timescale 1ns / 1ps
// Shared definitions for the shared-store stack block: sizes, pointer
// widths, codes, transaction types and pointer helper functions.
// No dependencies.
package kss_pkg;

    localparam int CAPACITY    = 16;
    localparam int STACK_COUNT = 4;

    localparam int PTR_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SIDX_W = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;

    localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(CAPACITY);

    localparam logic        REQ_PUSH = 1'b0;
    localparam logic        REQ_POP  = 1'b1;

    localparam logic [1:0]  ST_OK        = 2'd0;
    localparam logic [1:0]  ST_OVERFLOW  = 2'd1;
    localparam logic [1:0]  ST_UNDERFLOW = 2'd2;

    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic              req_type;
        logic [1:0]        stack_id;
        logic signed [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic signed [31:0] pop_value;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic check;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic fail;
    } stat_t;

    function automatic logic ptr_ok(logic [PTR_W-1:0] p);
        return p < NIL_PTR;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_norm(logic [PTR_W-1:0] p);
        return (p < NIL_PTR) ? p : NIL_PTR;
    endfunction

    function automatic logic [SIDX_W-1:0] sid_index(logic [1:0] sid);
        logic [SIDX_W+1:0] ext;
        ext = (SIDX_W + 2)'(sid);
        return ext[SIDX_W-1:0];
    endfunction

    function automatic logic sid_bad(logic [1:0] sid);
        return 32'(sid) >= STACK_COUNT;
    endfunction

endpackage

// ===== sv/kss_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/kss_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the shared-store stack block: handshakes and datapath steps.
// Depends on kss_pkg.
module kss_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output kss_pkg::cmd_t cmd,
    input  kss_pkg::stat_t stat
);
    import kss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TOP,
        S_LINK,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_TOP;
                end
            end
            S_TOP:
            begin
                state_next = stat.fail ? S_RESP : S_LINK;
            end
            S_LINK:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = (state_reg == S_RESP);
    assign cmd.load   = (state_reg == S_IDLE) && req_valid;
    assign cmd.check  = (state_reg == S_TOP);
    assign cmd.commit = (state_reg == S_LINK);

endmodule

// ===== sv/kss_dp.sv =====
`timescale 1ns / 1ps
// Datapath for the shared-store stack block: top pointers, free list,
// link and data stores, fill mark and result register.
// Depends on kss_pkg and kss_ram.
module kss_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  kss_pkg::cmd_t  cmd,
    output kss_pkg::stat_t stat,
    input  kss_pkg::req_t  req,
    output kss_pkg::rsp_t  rsp
);
    import kss_pkg::*;

    req_t              req_reg;
    rsp_t              rsp_reg;
    logic [PTR_W-1:0]  top_reg;
    logic [PTR_W-1:0]  slot_reg;
    logic [PTR_W-1:0]  free_head_reg;
    logic [PTR_W-1:0]  fill_reg;
    logic [STACK_COUNT-1:0] top_valid_reg;

    logic [SIDX_W-1:0] sidx;
    logic              is_push;
    logic [PTR_W-1:0]  top_rdata;
    logic [PTR_W-1:0]  top_cur;
    logic [PTR_W-1:0]  slot_sel;
    logic [PTR_W-1:0]  link_rdata;
    logic [31:0]       data_rdata;
    logic              untouched;
    logic [PTR_W-1:0]  next_link;

    logic              top_we;
    logic [PTR_W-1:0]  top_wdata;
    logic              link_we;
    logic [PTR_W-1:0]  link_wdata;
    logic              data_we;

    assign sidx    = sid_index(req_reg.stack_id);
    assign is_push = (req_reg.req_type == REQ_PUSH);
    assign top_cur = top_valid_reg[sidx] ? ptr_norm(top_rdata) : NIL_PTR;
    assign slot_sel = is_push ? free_head_reg : top_cur;

    assign stat.fail = sid_bad(req_reg.stack_id)
                     || (is_push ? !ptr_ok(free_head_reg) : !ptr_ok(top_cur));

    // slots at or past the fill mark have never been written; their link is taken as the next slot
    assign untouched = (slot_reg >= fill_reg);
    assign next_link = untouched ? ptr_norm(slot_reg + PTR_W'(1)) : ptr_norm(link_rdata);

    assign top_we     = cmd.commit;
    assign top_wdata  = is_push ? slot_reg : next_link;
    assign link_we    = cmd.commit;
    assign link_wdata = is_push ? top_reg : free_head_reg;
    assign data_we    = cmd.commit && is_push;

    kss_ram #(
        .WIDTH (PTR_W),
        .DEPTH (STACK_COUNT)
    ) u_top_ram (
        .clk   (clk),
        .we    (top_we),
        .waddr (sidx),
        .wdata (top_wdata),
        .raddr (sid_index(req.stack_id)),
        .rdata (top_rdata)
    );

    kss_ram #(
        .WIDTH (PTR_W),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (slot_reg[ADDR_W-1:0]),
        .wdata (link_wdata),
        .raddr (slot_sel[ADDR_W-1:0]),
        .rdata (link_rdata)
    );

    kss_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (slot_reg[ADDR_W-1:0]),
        .wdata (req_reg.push_value),
        .raddr (slot_sel[ADDR_W-1:0]),
        .rdata (data_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.check)
        begin
            top_reg  <= top_cur;
            slot_reg <= slot_sel;
            if (stat.fail)
            begin
                rsp_reg.status    <= is_push ? ST_OVERFLOW : ST_UNDERFLOW;
                rsp_reg.pop_value <= is_push ? 32'sd0 : INT_MAX;
            end
        end
        if (cmd.commit)
        begin
            rsp_reg.status    <= ST_OK;
            rsp_reg.pop_value <= is_push ? 32'sd0 : $signed(data_rdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            fill_reg      <= '0;
            top_valid_reg <= '0;
        end
        else if (cmd.commit)
        begin
            top_valid_reg[sidx] <= 1'b1;
            if (is_push)
            begin
                free_head_reg <= next_link;
                if (untouched)
                begin
                    fill_reg <= fill_reg + PTR_W'(1);
                end
            end
            else
            begin
                free_head_reg <= slot_reg;
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== sv/k_stacks_shared_array.sv =====
`timescale 1ns / 1ps
// Top level: several stacks sharing one slot store with a free list.
// Depends on kss_pkg, kss_ctrl, kss_dp (and kss_ram through kss_dp).
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------
//  request | req_valid | req_stall | req (req_type, stack_id, push_value)
//  result  | rsp_valid | rsp_stall | rsp (status, pop_value)
//
// A transaction offers its result after one registered read of the top-pointer
// store, then one of the link and data stores, then the update; on overflow or
// underflow it is offered straight after the top-pointer read. A new request is
// taken the cycle after the result leaves, so one transaction runs at a time.
// Reset empties all stacks at once; the datapath keeps a fill mark, so no
// clearing pass runs. The result waits in its register while rsp_stall holds.
module k_stacks_shared_array (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  kss_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output kss_pkg::rsp_t rsp
);
    import kss_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    kss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    kss_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// ===== tb/sv/tb_kss_stack_shadow_pkg.sv =====
`timescale 1ns / 1ps
// Shadow of the shared-store stacks: tracks slots, links, tops and the free
// list, and holds the responses still due. Depends on kss_pkg.
package tb_kss_stack_shadow_pkg;

    import kss_pkg::*;

    class stack_shadow;
        logic signed [31:0] slot_data [CAPACITY];
        logic [PTR_W-1:0]   slot_link [CAPACITY];
        logic [PTR_W-1:0]   stack_top [STACK_COUNT];
        logic [PTR_W-1:0]   free_head;
        rsp_t               due_rsp [$];
        int                 errors;

        function new();
            for (int i = 0; i < CAPACITY; i++)
            begin
                slot_link[i] = PTR_W'(i + 1);
            end
            slot_link[CAPACITY-1] = NIL_PTR;
            for (int i = 0; i < STACK_COUNT; i++)
            begin
                stack_top[i] = NIL_PTR;
            end
            free_head = '0;
            errors    = 0;
        endfunction

        function void apply_request(req_t r);
            rsp_t             e;
            int               sid;
            logic [PTR_W-1:0] slot;
            sid         = int'(r.stack_id);
            e.pop_value = '0;
            if (r.req_type == REQ_PUSH)
            begin
                if (sid >= STACK_COUNT || free_head >= NIL_PTR)
                begin
                    e.status = ST_OVERFLOW;
                end
                else
                begin
                    slot      = free_head;
                    free_head = slot_link[slot];
                    if (free_head >= NIL_PTR)
                    begin
                        free_head = NIL_PTR;
                    end
                    slot_link[slot] = stack_top[sid];
                    stack_top[sid]  = slot;
                    slot_data[slot] = r.push_value;
                    e.status        = ST_OK;
                end
            end
            else
            begin
                if (sid >= STACK_COUNT || stack_top[sid] >= NIL_PTR)
                begin
                    e.status    = ST_UNDERFLOW;
                    e.pop_value = INT_MAX;
                end
                else
                begin
                    slot           = stack_top[sid];
                    stack_top[sid] = slot_link[slot];
                    if (stack_top[sid] >= NIL_PTR)
                    begin
                        stack_top[sid] = NIL_PTR;
                    end
                    slot_link[slot] = free_head;
                    free_head       = slot;
                    e.status        = ST_OK;
                    e.pop_value     = slot_data[slot];
                end
            end
            due_rsp.push_back(e);
        endfunction

        function void check_response(rsp_t a);
            rsp_t e;
            if (due_rsp.size() == 0)
            begin
                $display("%0t: unexpected response status=%0d pop_value=%0d",
                         $time, a.status, a.pop_value);
                errors++;
                return;
            end
            e = due_rsp.pop_front();
            if (a.status !== e.status)
            begin
                $display("%0t: status mismatch expected=%0d actual=%0d",
                         $time, e.status, a.status);
                errors++;
            end
            if (a.pop_value !== e.pop_value)
            begin
                $display("%0t: pop_value mismatch expected=%0d actual=%0d",
                         $time, e.pop_value, a.pop_value);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_k_stacks_shared_array.sv =====
`timescale 1ns / 1ps
// Testbench for k_stacks_shared_array: directed and random push/pop traffic
// with bursty requests and patterned response stalls, checked against a shadow
// of the stacks. Depends on kss_pkg and tb_kss_stack_shadow_pkg.
module tb_k_stacks_shared_array;

    import kss_pkg::*;
    import tb_kss_stack_shadow_pkg::*;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_stall;
    rsp_t  rsp;

    stack_shadow shadow = new();
    int          stall_cycle;

    k_stacks_shared_array uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #500000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                shadow.apply_request(req);
            end
            if (rsp_valid && !rsp_stall)
            begin
                shadow.check_response(rsp);
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_cycle <= 0;
            rsp_stall   <= 1'b0;
        end
        else
        begin
            stall_cycle <= stall_cycle + 1;
            case (stall_cycle[8:7])
                2'd0: rsp_stall <= 1'b0;
                2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
                2'd2: rsp_stall <= 1'($urandom_range(0, 1));
                default: rsp_stall <= (stall_cycle[3:0] < 4'd10);
            endcase
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return INT_MAX;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t make_req(logic kind, logic [1:0] sid,
                                      logic signed [31:0] value);
        req_t r;
        r.req_type   = kind;
        r.stack_id   = sid;
        r.push_value = value;
        return r;
    endfunction

    task automatic send(input req_t r);
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            req_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (shadow.due_rsp.size() != 0);
    endtask

    initial
    begin
        int   burst_left;
        int   push_pct;
        logic kind;
        logic [1:0] sid;
        logic signed [31:0] fill_vals [16];

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        fill_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1,
                      32'sh5555_5555, 32'shAAAA_AAAA, 32'sd1, 32'sh7FFF_FFFE,
                      32'sh8000_0001, 32'sh0F0F_0F0F, 32'shF0F0_F0F0, 32'sh1234_5678,
                      32'shDEAD_BEEF, 32'sh0000_FFFF, 32'shFFFF_0000, 32'sh3C3C_C3C3};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pop every empty stack
        for (int s = 0; s < 4; s++)
        begin
            send(make_req(REQ_POP, 2'(s), $urandom));
        end
        // fill the whole store across all stacks, then overflow
        for (int i = 0; i < 16; i++)
        begin
            send(make_req(REQ_PUSH, 2'(i % 4), fill_vals[i]));
            pause(i % 3);
        end
        send(make_req(REQ_PUSH, 2'd2, 32'sh7FFF_FFFF));
        send(make_req(REQ_POP, 2'd1, 32'sh8000_0000));
        send(make_req(REQ_POP, 2'd1, -32'sd1));
        send(make_req(REQ_POP, 2'd3, 32'sd0));

        // hold until every response is back
        drain();

        burst_left = 0;
        push_pct   = 50;
        for (int n = 0; n < 700; n++)
        begin
            if (n % 50 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: push_pct = 80;
                    1: push_pct = 50;
                    default: push_pct = 20;
                endcase
            end
            kind = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
            sid  = ((n / 70) % 2 == 1) ? 2'($urandom_range(0, 1) * 3)
                                       : 2'($urandom_range(0, 3));
            send(make_req(kind, sid, kind == REQ_PUSH ? pick_value() : $urandom));
            if (n == 350)
            begin
                drain();
            end
            else if ((n / 100) % 3 != 0)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    pause($urandom_range(1, 6));
                end
                else
                begin
                    burst_left--;
                end
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (shadow.due_rsp.size() != 0)
        begin
            $display("%0t: %0d responses never arrived", $time, shadow.due_rsp.size());
        end
        if (shadow.errors == 0 && shadow.due_rsp.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/kss_pkg.sv
sv/kss_ram.sv
sv/kss_ctrl.sv
sv/kss_dp.sv
sv/k_stacks_shared_array.sv
tb/sv/tb_kss_stack_shadow_pkg.sv
tb/sv/tb_k_stacks_shared_array.sv
